[src/ray_sphere_intersect_unit_assert.svh]
// ----------------------------------------------------------------------------
// ray_sphere_intersect_unit_assert.svh
// assertion macros shared by the ray / sphere intersection unit
// ----------------------------------------------------------------------------
`ifndef RAY_SPHERE_INTERSECT_UNIT_ASSERT_SVH
`define RAY_SPHERE_INTERSECT_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RSI_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define RSI_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[src/rsi_pkg.sv]
// ----------------------------------------------------------------------------
// rsi_pkg
// shared widths and types of the ray / sphere intersection unit
// ----------------------------------------------------------------------------
package rsi_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int S_TDATA_W     = 320;
    localparam int M_TDATA_W     = 40;
    localparam int QDEPTH        = 4;
    localparam int QPTR_W        = $clog2(QDEPTH);

    // quadratic term widths
    localparam int A_W    = 64;
    localparam int H_W    = 66;
    localparam int C_W    = 68;
    localparam int DISC_W = 132;
    localparam int ROOT_W = DISC_W / 2;

    // request handed from the front part to the back part
    typedef struct packed {
        logic                miss;
        logic                near;
        logic [DISC_W-1:0]   disc;
        logic [H_W-1:0]      h;
        logic [A_W-1:0]      a;
    } rsi_job_t;

    // front part status
    typedef struct packed {
        logic last_valid;
        logic stalled;
    } rsi_front_stat_t;

endpackage

[src/rsi_front.sv]
// ----------------------------------------------------------------------------
// rsi_front
// accepts requests, forms a, half_b, c and the discriminant, classifies hits
// ----------------------------------------------------------------------------
module rsi_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, center_x, center_y,
    // center_z, sphere_radius (31 bits), one zero pad bit
    input  logic [rsi_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                       job_valid,
    output rsi_pkg::rsi_job_t          job,
    input  logic                       q_full,
    output rsi_pkg::rsi_front_stat_t   stat
);
    import rsi_pkg::*;

    logic [5:0] v_reg;
    logic       adv;

    // stage 1: origin minus center, direction, radius
    logic signed [32:0] oc_reg [3];
    logic signed [31:0] d_reg  [3];
    logic [30:0]        r_reg;
    // stage 2: products
    logic signed [63:0] dd_reg [3];
    logic signed [64:0] od_reg [3];
    logic signed [65:0] oo_reg [3];
    logic [61:0]        rr_reg;
    // stage 3: sums
    logic [A_W-1:0]     a3_reg;
    logic [H_W-1:0]     h3_reg;
    logic [C_W-1:0]     c3_reg;
    logic [A_W-1:0]     a3_next;
    logic [H_W-1:0]     h3_next;
    logic [C_W-1:0]     c3_next;
    // stage 4: partial products and sign flags
    logic [65:0]        phh_reg;
    logic [64:0]        phl_reg;
    logic [63:0]        pll_reg;
    logic [65:0]        qhh_reg;
    logic [63:0]        qhl_reg;
    logic [65:0]        qlh_reg;
    logic [63:0]        qll_reg;
    logic [H_W-1:0]     h4_reg;
    logic [A_W-1:0]     a4_reg;
    logic [3:0]         f4_reg;
    logic [H_W-1:0]     hmag;
    logic [C_W-1:0]     cmag;
    // stage 5: h squared and a times c
    logic [129:0]       h2_reg;
    logic [129:0]       ac_reg;
    logic [H_W-1:0]     h5_reg;
    logic [A_W-1:0]     a5_reg;
    logic [3:0]         f5_reg;
    // stage 6: discriminant and classification
    logic [DISC_W-1:0]  d6_next;
    rsi_job_t           job_reg;

    // whole front moves unless its last request is blocked by the queue
    assign adv      = !v_reg[5] || !q_full;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[4:0], s_tvalid};
        end
    end

    // stage 1
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                oc_reg[i] <= $signed({s_tdata[32*i+31], s_tdata[32*i +: 32]})
                           - $signed({s_tdata[32*(i+6)+31], s_tdata[32*(i+6) +: 32]});
                d_reg[i]  <= $signed(s_tdata[32*(i+3) +: 32]);
            end
            r_reg <= s_tdata[288 +: 31];
        end
    end

    // stage 2
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dd_reg[i] <= d_reg[i] * d_reg[i];
                od_reg[i] <= oc_reg[i] * d_reg[i];
                oo_reg[i] <= oc_reg[i] * oc_reg[i];
            end
            rr_reg <= r_reg * r_reg;
        end
    end

    // stage 3 sums, all exact
    always_comb
    begin
        a3_next = dd_reg[0] + dd_reg[1] + dd_reg[2];
        h3_next = {od_reg[0][64], od_reg[0]} + {od_reg[1][64], od_reg[1]}
                + {od_reg[2][64], od_reg[2]};
        c3_next = {2'b00, oo_reg[0]} + {2'b00, oo_reg[1]} + {2'b00, oo_reg[2]}
                - {6'd0, rr_reg};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a3_reg <= a3_next;
            h3_reg <= h3_next;
            c3_reg <= c3_next;
        end
    end

    // stage 4: magnitudes split into halves
    assign hmag = h3_reg[H_W-1] ? (~h3_reg + 1'b1) : h3_reg;
    assign cmag = c3_reg[C_W-1] ? (~c3_reg + 1'b1) : c3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            phh_reg <= hmag[64:32] * hmag[64:32];
            phl_reg <= hmag[64:32] * hmag[31:0];
            pll_reg <= hmag[31:0] * hmag[31:0];
            qhh_reg <= a3_reg[63:32] * cmag[65:32];
            qhl_reg <= a3_reg[63:32] * cmag[31:0];
            qlh_reg <= a3_reg[31:0] * cmag[65:32];
            qll_reg <= a3_reg[31:0] * cmag[31:0];
            h4_reg  <= h3_reg;
            a4_reg  <= a3_reg;
            // a zero, h negative, c negative, c positive
            f4_reg  <= {a3_reg == '0, h3_reg[H_W-1], c3_reg[C_W-1],
                        !c3_reg[C_W-1] && (c3_reg != '0)};
        end
    end

    // stage 5: sum partial products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h2_reg <= (130'(phh_reg) << 64) + (130'(phl_reg) << 33) + 130'(pll_reg);
            ac_reg <= (130'(qhh_reg) << 64) + ((130'(qhl_reg) + 130'(qlh_reg)) << 32)
                    + 130'(qll_reg);
            h5_reg <= h4_reg;
            a5_reg <= a4_reg;
            f5_reg <= f4_reg;
        end
    end

    // stage 6: discriminant, c sign decides add or subtract
    assign d6_next = f5_reg[1] ? (DISC_W'(h2_reg) + DISC_W'(ac_reg))
                               : (DISC_W'(h2_reg) - DISC_W'(ac_reg));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            job_reg.miss <= f5_reg[3] || d6_next[DISC_W-1] || !(f5_reg[2] || f5_reg[1]);
            job_reg.near <= f5_reg[2] && f5_reg[0];
            job_reg.disc <= d6_next;
            job_reg.h    <= h5_reg;
            job_reg.a    <= a5_reg;
        end
    end

    assign job_valid       = v_reg[5];
    assign job             = job_reg;
    assign stat.last_valid = v_reg[5];
    assign stat.stalled    = v_reg[5] && q_full;

endmodule

[src/rsi_queue.sv]
// ----------------------------------------------------------------------------
// rsi_queue
// short queue of requests between the front and back parts
// ----------------------------------------------------------------------------
module rsi_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rsi_pkg::rsi_job_t  push_data,
    output logic               full,
    input  logic               pop,
    output rsi_pkg::rsi_job_t  pop_data,
    output logic               empty
);
    import rsi_pkg::*;

    rsi_job_t          entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full     = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[src/rsi_back.sv]
// ----------------------------------------------------------------------------
// rsi_back
// square root of the discriminant, root numerator, quotient and saturation
// ----------------------------------------------------------------------------
module rsi_back
#(
    parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  rsi_pkg::rsi_job_t             job,
    input  logic                          job_empty,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // hit, hit_distance (32 bits), seven zero pad bits
    output logic [rsi_pkg::M_TDATA_W-1:0] m_tdata
);
    import rsi_pkg::*;

    localparam int NUM_W = H_W + 1;
    localparam int N_W   = NUM_W + FRAC_BITS;
    localparam int CMP_W = (N_W > A_W + 32) ? N_W : A_W + 32;
    localparam int REM_W = ROOT_W + 2;
    localparam int DR_W  = A_W + 1;

    logic adv;

    // square root stages
    logic              sq_v_reg    [ROOT_W+1];
    logic [DISC_W-1:0] sq_disc_reg [ROOT_W+1];
    logic [ROOT_W-1:0] sq_root_reg [ROOT_W+1];
    logic [REM_W-1:0]  sq_rem_reg  [ROOT_W+1];
    logic [H_W-1:0]    sq_h_reg    [ROOT_W+1];
    logic [A_W-1:0]    sq_a_reg    [ROOT_W+1];
    logic              sq_miss_reg [ROOT_W+1];
    logic              sq_near_reg [ROOT_W+1];

    // numerator stage
    logic              n1_v_reg;
    logic [NUM_W-1:0]  n1_num_reg;
    logic [A_W-1:0]    n1_a_reg;
    logic              n1_miss_reg;
    logic [NUM_W:0]    neg_h;
    logic [N_W-1:0]    n_val;

    // divider stages
    logic              dv_v_reg    [33];
    logic [DR_W-1:0]   dv_rem_reg  [33];
    logic [31:0]       dv_nlo_reg  [33];
    logic [31:0]       dv_q_reg    [33];
    logic [A_W-1:0]    dv_a_reg    [33];
    logic              dv_miss_reg [33];
    logic              dv_sat_reg  [33];

    // output register
    logic              out_v_reg;
    logic              out_hit_reg;
    logic [31:0]       out_dist_reg;

    // the whole back part stalls only on a held result
    assign adv      = !out_v_reg || m_tready;
    assign pop      = adv && !job_empty;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = {7'd0, out_dist_reg, out_hit_reg};

    // entry stage from the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            sq_v_reg[0] <= !job_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_disc_reg[0] <= job.disc;
            sq_root_reg[0] <= '0;
            sq_rem_reg[0]  <= '0;
            sq_h_reg[0]    <= job.h;
            sq_a_reg[0]    <= job.a;
            sq_miss_reg[0] <= job.miss;
            sq_near_reg[0] <= job.near;
        end
    end

    // one root bit per stage, restoring square root
    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sqrt
        logic [REM_W-1:0] tmp;
        logic [REM_W-1:0] trial;
        logic             ge;

        assign tmp   = {sq_rem_reg[k][REM_W-3:0], sq_disc_reg[k][DISC_W-1-2*k -: 2]};
        assign trial = {sq_root_reg[k], 2'b01};
        assign ge    = (tmp >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                sq_v_reg[k+1] <= sq_v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_disc_reg[k+1] <= sq_disc_reg[k];
                sq_root_reg[k+1] <= {sq_root_reg[k][ROOT_W-2:0], ge};
                sq_rem_reg[k+1]  <= ge ? (tmp - trial) : tmp;
                sq_h_reg[k+1]    <= sq_h_reg[k];
                sq_a_reg[k+1]    <= sq_a_reg[k];
                sq_miss_reg[k+1] <= sq_miss_reg[k];
                sq_near_reg[k+1] <= sq_near_reg[k];
            end
        end
    end

    // numerator: nearer root subtracts the root, farther root adds it
    assign neg_h = '0 - {{2{sq_h_reg[ROOT_W][H_W-1]}}, sq_h_reg[ROOT_W]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n1_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            n1_v_reg <= sq_v_reg[ROOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (sq_near_reg[ROOT_W])
            begin
                n1_num_reg <= NUM_W'(neg_h - (NUM_W+1)'(sq_root_reg[ROOT_W]));
            end
            else
            begin
                n1_num_reg <= NUM_W'(neg_h + (NUM_W+1)'(sq_root_reg[ROOT_W]));
            end
            n1_a_reg    <= sq_a_reg[ROOT_W];
            n1_miss_reg <= sq_miss_reg[ROOT_W];
        end
    end

    // saturation check and divider setup
    assign n_val = {n1_num_reg, {FRAC_BITS{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            dv_v_reg[0] <= n1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_sat_reg[0]  <= (CMP_W'(n_val) >= CMP_W'({n1_a_reg, 32'd0}));
            dv_rem_reg[0]  <= DR_W'(n_val[N_W-1:32]);
            dv_nlo_reg[0]  <= n_val[31:0];
            dv_q_reg[0]    <= '0;
            dv_a_reg[0]    <= n1_a_reg;
            dv_miss_reg[0] <= n1_miss_reg;
        end
    end

    // one quotient bit per stage, restoring division
    for (genvar k = 0; k < 32; k++)
    begin : g_div
        logic [DR_W-1:0] t;
        logic            ge;

        assign t  = {dv_rem_reg[k][A_W-1:0], dv_nlo_reg[k][31-k]};
        assign ge = (t >= {1'b0, dv_a_reg[k]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv_v_reg[k+1] <= dv_v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_rem_reg[k+1]  <= ge ? (t - {1'b0, dv_a_reg[k]}) : t;
                dv_nlo_reg[k+1]  <= dv_nlo_reg[k];
                dv_q_reg[k+1]    <= {dv_q_reg[k][30:0], ge};
                dv_a_reg[k+1]    <= dv_a_reg[k];
                dv_miss_reg[k+1] <= dv_miss_reg[k];
                dv_sat_reg[k+1]  <= dv_sat_reg[k];
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_v_reg <= dv_v_reg[32];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_hit_reg <= !dv_miss_reg[32];
            if (dv_miss_reg[32])
            begin
                out_dist_reg <= '0;
            end
            else if (dv_sat_reg[32])
            begin
                out_dist_reg <= '1;
            end
            else
            begin
                out_dist_reg <= dv_q_reg[32];
            end
        end
    end

endmodule

[src/ray_sphere_intersect_unit.sv]
// ----------------------------------------------------------------------------
// ray_sphere_intersect_unit
// fixed point ray / sphere intersection, one test per request
// ----------------------------------------------------------------------------
// Takes one ray / sphere request per cycle when nothing stalls and returns
// one result per request in order. The front part (six stages) forms a,
// half_b, c and the discriminant exactly and classifies the request. A
// four-entry queue separates it from the back part. The back part has one
// entry stage, then takes one root bit per stage over 66 stages of square
// root and one quotient bit per stage over 32 stages of division, with two
// stages for numerator and saturation, then a result register. Throughput is
// one request per cycle when nothing stalls, set by the fully pipelined
// square root and divider.
module ray_sphere_intersect_unit
#(
    parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, center_x, center_y,
    // center_z, sphere_radius (31 bits), one zero pad bit
    input  logic [rsi_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // hit, hit_distance (32 bits), seven zero pad bits
    output logic [rsi_pkg::M_TDATA_W-1:0] m_tdata
);
    import rsi_pkg::*;

`include "ray_sphere_intersect_unit_assert.svh"

    logic            job_valid;
    rsi_job_t        job_in;
    rsi_job_t        job_out;
    logic            q_full;
    logic            q_empty;
    logic            q_push;
    logic            q_pop;
    rsi_front_stat_t fstat;

    assign q_push = job_valid && !q_full;

    // front part
    rsi_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .job_valid (job_valid),
        .job       (job_in),
        .q_full    (q_full),
        .stat      (fstat)
    );

    // request queue
    rsi_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (job_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (job_out),
        .empty     (q_empty)
    );

    // back part
    rsi_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job_out),
        .job_empty (q_empty),
        .pop       (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // checks
    `RSI_ASSERT_NOW(a_miss_zero, clk, rst_n, m_tvalid && !m_tdata[0],
        m_tdata[32:1] == '0, "miss with nonzero distance")
    `RSI_ASSERT_NOW(a_ready_stall, clk, rst_n, !s_tready, fstat.stalled,
        "input held back without a full queue")
    `RSI_ASSERT_NOW(a_stall_valid, clk, rst_n, fstat.stalled,
        fstat.last_valid && q_full && !q_push, "stalled front without a request")

endmodule

[bench/rsi_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rsi_checker
// watches both streams of the ray / sphere unit and checks every result
// ----------------------------------------------------------------------------
// Each accepted request is run through a wide-integer model of the
// intersection test: exact quadratic terms, integer square root and a
// truncating divide. The expected hit flag and distance are queued in order
// and compared field by field with each accepted result.
module rsi_checker
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [rsi_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [rsi_pkg::M_TDATA_W-1:0] m_tdata,
    output int                            errors,
    output int                            pending,
    output int                            hits
);

    typedef logic signed [199:0] wide_t;

    typedef struct {
        logic        hit;
        logic [31:0] distance;
    } hit_result_t;

    hit_result_t awaited_hits[$];

    // exact ray / sphere test, nearer positive root first
    function automatic hit_result_t trace_ray(input logic [rsi_pkg::S_TDATA_W-1:0] req);
        wide_t       a, h, c, d, oc, r, disc, root, cand, num, n, lim;
        hit_result_t res;
        int          i;
        a = 0;
        h = 0;
        c = 0;
        res.hit      = 1'b0;
        res.distance = '0;
        for (i = 0; i < 3; i++)
        begin
            d  = $signed(req[96 + 32*i +: 32]);
            oc = $signed(req[32*i +: 32]) - $signed(req[192 + 32*i +: 32]);
            a  = a + d * d;
            h  = h + oc * d;
            c  = c + oc * oc;
        end
        r    = $signed({1'b0, req[318:288]});
        c    = c - r * r;
        disc = h * h - a * c;
        if (a == 0 || disc < 0)
            return res;
        // integer square root, one bit at a time
        root = 0;
        for (i = 66; i >= 0; i--)
        begin
            cand = root | (wide_t'(1) << i);
            if (cand * cand <= disc)
                root = cand;
        end
        if (h < 0 && c > 0)
            num = -h - root;
        else if (h < 0 || c < 0)
            num = -h + root;
        else
            return res;
        n   = num <<< FRAC_BITS;
        lim = a <<< 32;
        res.hit = 1'b1;
        if (n >= lim)
            res.distance = '1;
        else
            res.distance = 32'(n / a);
        return res;
    endfunction

    assign pending = awaited_hits.size();

    // predict on request, compare on result
    always @(posedge clk or negedge rst_n)
    begin
        hit_result_t want;
        if (!rst_n)
        begin
            errors = 0;
            hits   = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                awaited_hits.push_back(trace_ray(s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (awaited_hits.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with nothing expected: %h", $time, m_tdata);
                end
                else
                begin
                    want = awaited_hits.pop_front();
                    if (want.hit)
                        hits++;
                    if (m_tdata[0] !== want.hit)
                    begin
                        errors++;
                        $display("%0t: hit expected %b actual %b", $time, want.hit,
                                 m_tdata[0]);
                    end
                    if (m_tdata[32:1] !== want.distance)
                    begin
                        errors++;
                        $display("%0t: hit_distance expected %h actual %h", $time,
                                 want.distance, m_tdata[32:1]);
                    end
                    if (m_tdata[39:33] !== 7'd0)
                    begin
                        errors++;
                        $display("%0t: pad expected 0 actual %h", $time, m_tdata[39:33]);
                    end
                end
            end
        end
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the ray / sphere intersection unit
// ----------------------------------------------------------------------------
// Directed rays cover the corner cases (zero direction, tangent, origin inside,
// sphere behind, sub-step and saturated distances, extreme values), then a
// random mix of aimed rays and raw bit patterns runs with random gaps on both
// streams. The checker beside the block does all prediction.
module testbench;

    localparam int   ONE       = 32'h0001_0000;
    localparam int   N_RANDOM  = 2000;
    localparam int   IDLE_PCT  = 14;
    localparam int   DOG_LIMIT = 5000;

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [rsi_pkg::S_TDATA_W-1:0] s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [rsi_pkg::M_TDATA_W-1:0] m_tdata;
    int                            errors;
    int                            pending;
    int                            hits;
    int                            sent;
    int                            quiet;
    logic                          calm;

    ray_sphere_intersect_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    rsi_checker scoreboard
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending),
        .hits     (hits)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver stalls
    always @(posedge clk)
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);

    // watchdog on accepted requests and results
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= DOG_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", DOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // drive one request and hold it until taken
    task automatic send_ray(input logic [31:0] ox, oy, oz, dx, dy, dz, cx, cy, cz,
                            input logic [30:0] rad);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom};
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, rad, cz, cy, cx, dz, dy, dx, oz, oy, ox};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
    endtask

    // ray aimed near the sphere, small coordinates
    task automatic send_aimed();
        logic signed [31:0] ox, oy, oz, cx, cy, cz, jit;
        logic [30:0]        rad;
        int                 sh;
        sh  = $urandom_range(26, 12);
        ox  = $signed($urandom) >>> sh;
        oy  = $signed($urandom) >>> sh;
        oz  = $signed($urandom) >>> sh;
        cx  = $signed($urandom) >>> sh;
        cy  = $signed($urandom) >>> sh;
        cz  = $signed($urandom) >>> sh;
        rad = 31'($urandom) >> (sh - 1);
        jit = $signed($urandom) >>> (sh + 2);
        if ($urandom_range(3) == 0)
            send_ray(ox, oy, oz, cx - ox, cy - oy + jit, cz - oz, cx, cy, cz, rad);
        else
            send_ray(ox, oy, oz, (cx - ox) >>> 2, (cy - oy + jit) >>> 3, cz - oz,
                     cx, cy, cz, rad);
    endtask

    initial
    begin
        calm     = 1'b0;
        sent     = 0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corner cases
        send_ray(0, 0, -10*ONE, 0, 0, 0, 0, 0, 0, ONE);                     // zero direction
        send_ray(0, 0, -10*ONE, 0, 0, ONE, 0, 0, 0, ONE);                   // plain hit
        send_ray(ONE, 0, -10*ONE, 0, 0, ONE, 0, 0, 0, ONE);                 // tangent
        send_ray(5*ONE, 0, -10*ONE, 0, 0, ONE, 0, 0, 0, ONE);               // discriminant negative
        send_ray(0, 0, 0, 0, 0, ONE, 0, 0, 0, 2*ONE);                       // origin inside
        send_ray(0, 0, 10*ONE, 0, 0, ONE, 0, 0, 0, ONE);                    // sphere behind
        send_ray(0, 0, -ONE-1, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, ONE);          // sub-step root
        send_ray(0, 0, -30000*ONE, 0, 0, 1, 0, 0, 0, ONE);                  // saturated
        send_ray(0, 0, 0, 0, 0, ONE, 0, 0, 0, 0);                           // zero radius
        send_ray(0, 0, -ONE, 0, 0, ONE, 0, 0, 0, 0);                        // point sphere
        send_ray(0, 0, 0, ONE, ONE, ONE, 0, 0, 0, 0);                       // origin on point
        send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 31'h7FFF_FFFF);
        send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_ray(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 0, 0, 1);
        send_ray('1, '1, '1, '1, '1, '1, '1, '1, '1, '1);
        send_ray(0, 0, 0, 1, 0, 0, 0, 0, 0, 31'h7FFF_FFFF);                 // huge sphere
        send_ray(ONE, 0, 0, 0, ONE, 0, 0, 0, 0, ONE);                       // grazing at t=0
        send_ray(0, 0, -ONE, 0, 0, ONE, 0, 0, 0, ONE);                      // near root at zero

        // random part, with one long stretch free of gaps
        for (int i = 0; i < N_RANDOM; i++)
        begin
            calm = (i >= 600 && i < 900);
            if ($urandom_range(99) < 75)
                send_aimed();
            else
                send_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, 31'($urandom));
        end
        s_tvalid <= 1'b0;

        // drain, then let the pipe settle
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("sent %0d ray / sphere requests, %0d of them hits", sent, hits);
        $display("directed corners, aimed rays and raw patterns under random stalls");
        if (errors == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
